>>> rtl/assert_macros.svh
// Assertion macros for the top module of the payload matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/mlpm_pkg.sv
// Package with the request, result and pattern write types of the payload matcher.
package mlpm_pkg;

	localparam int ACTIVE_W = 4;
	localparam int MASK_W   = 8;

	localparam logic [1:0] MODE_PAYLOAD  = 2'd0;
	localparam logic [1:0] MODE_PAT_BYTE = 2'd1;
	localparam logic [1:0] MODE_PAT_LEN  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       last;
		logic       empty_packet;
		logic [2:0] pattern_index;
		logic [4:0] pattern_pos;
		logic [5:0] pattern_len;
	} req_t;

	typedef struct packed {
		logic [MASK_W-1:0] match_mask;
		logic              no_match;
	} res_t;

	// Write port of one pattern lane.
	typedef struct packed {
		logic       byte_we;
		logic       len_we;
		logic [4:0] pos;
		logic [7:0] data;
		logic [5:0] len;
	} pat_wr_t;

endpackage

>>> rtl/multi_literal_payload_matcher.sv
// Multi-literal payload matcher: each request is accepted into an input register and
// fully processed as it moves on from there, so one request per clock is taken when the
// result side does not stall. Payload requests shift a byte window, and all enabled
// pattern lanes compare their pattern against that window in parallel as the request
// moves on. A request that ends a packet loads the result register when it moves on from
// the input register. The input keeps flowing while a result waits, unless the request in
// the input register also ends a packet; that request then holds, and the input with it,
// until the waiting result is taken.
// Only the first SCAN_LIMIT bytes of a packet are scanned; later bytes only end it.
// Pattern bytes and lengths are written through the request channel itself and take
// effect from the next scanned byte. No clearing pass is needed after reset.
`include "assert_macros.svh"

module multi_literal_payload_matcher #(
	parameter int NUM_PATTERNS    = 8,
	parameter int MAX_PATTERN_LEN = 32,
	parameter int SCAN_LIMIT      = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mlpm_pkg::ACTIVE_W-1:0]    cfg_wdata,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  mlpm_pkg::req_t                   req,
	output logic                             res_valid,
	input  logic                             res_stall,
	output mlpm_pkg::res_t                   res
);
	import mlpm_pkg::*;

	localparam int CNT_W     = $clog2(SCAN_LIMIT + 1);
	localparam int WIN_DEPTH = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;

	// Configuration: number of lanes that take part in matching.
	logic [ACTIVE_W-1:0] active_q;

	// Input register stage.
	req_t req_s1;
	logic valid_s1;

	// Per-packet scan state. The window holds the older bytes; the newest byte comes
	// straight from the input register.
	logic [WIN_DEPTH-1:0][7:0] win_q;
	logic [CNT_W-1:0]          seen_q;
	logic [NUM_PATTERNS-1:0]   found_q;

	// Result register.
	res_t res_q;
	logic res_valid_q;

	logic                            is_payload;
	logic                            ends;
	logic                            do_scan;
	logic                            advance;
	logic                            s1_fire;
	logic                            accept;
	logic [CNT_W-1:0]                seen_next;
	logic [MAX_PATTERN_LEN-1:0][7:0] window_next;
	logic [NUM_PATTERNS-1:0]         enable;
	logic [NUM_PATTERNS-1:0]         hits;
	logic [NUM_PATTERNS-1:0]         found_upd;
	logic [MASK_W-1:0]               mask_next;
	pat_wr_t                         lane_wr [NUM_PATTERNS];

	// A request that ends a packet can only move on when the result register is free
	// or being emptied in this cycle; every other request moves on at once.
	assign is_payload = valid_s1 && (req_s1.mode == MODE_PAYLOAD);
	assign ends       = is_payload && req_s1.last;
	assign do_scan    = is_payload && !(req_s1.last && req_s1.empty_packet)
		&& (seen_q < CNT_W'(SCAN_LIMIT));
	assign advance    = !ends || !res_valid_q || !res_stall;
	assign s1_fire    = valid_s1 && advance;
	assign req_stall  = valid_s1 && !advance;
	assign accept     = req_valid && !req_stall;
	assign seen_next  = seen_q + CNT_W'(1);

	assign window_next[0] = req_s1.data_byte;
	for (genvar k = 1; k < MAX_PATTERN_LEN; k++) begin : g_win
		assign window_next[k] = win_q[k-1];
	end

	// One lane per pattern; each lane sees only the writes addressed to it.
	for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_lane
		always_comb begin
			lane_wr[p].byte_we = s1_fire && (req_s1.mode == MODE_PAT_BYTE)
				&& (int'(req_s1.pattern_index) == p);
			lane_wr[p].len_we  = s1_fire && (req_s1.mode == MODE_PAT_LEN)
				&& (int'(req_s1.pattern_index) == p);
			lane_wr[p].pos     = req_s1.pattern_pos;
			lane_wr[p].data    = req_s1.data_byte;
			lane_wr[p].len     = req_s1.pattern_len;
		end

		assign enable[p] = p < int'(active_q);

		mlpm_lane #(
			.MAX_PATTERN_LEN(MAX_PATTERN_LEN),
			.CNT_W          (CNT_W)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.wr    (lane_wr[p]),
			.enable(enable[p]),
			.window(window_next),
			.seen  (seen_next),
			.hit   (hits[p])
		);
	end

	assign found_upd = found_q | (do_scan ? hits : '0);

	// The reported mask covers the first MASK_W lanes.
	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < NUM_PATTERNS) begin : g_used
			assign mask_next[i] = found_upd[i];
		end else begin : g_unused
			assign mask_next[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// Counters restart at the end of every packet. The window needs no clearing:
	// a lane only compares positions filled within the current packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			found_q <= '0;
		end else if (s1_fire) begin
			if (ends) begin
				seen_q  <= '0;
				found_q <= '0;
			end else if (do_scan) begin
				seen_q  <= seen_next;
				found_q <= found_upd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && do_scan) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= window_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && ends) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ends) begin
			res_q.match_mask <= mask_next;
			res_q.no_match   <= (mask_next == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_IMPL(a_seen_bound, clk, arst_n, 1'b1, seen_q <= CNT_W'(SCAN_LIMIT))
	`ASSERT_IMPL(a_no_match, clk, arst_n, res_valid, res.no_match == (res.match_mask == '0))
	`ASSERT_NEXT(a_pkt_clear, clk, arst_n, s1_fire && ends, seen_q == '0 && found_q == '0)
	`ASSERT_IMPL(a_hold_end, clk, arst_n, ends && res_valid && res_stall, req_stall)

endmodule

>>> rtl/mlpm_lane.sv
// One pattern lane: pattern bytes, pattern length and the window comparator.
module mlpm_lane #(
	parameter int MAX_PATTERN_LEN = 32,
	parameter int CNT_W           = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlpm_pkg::pat_wr_t               wr,
	input  logic                            enable,
	input  logic [MAX_PATTERN_LEN-1:0][7:0] window,
	input  logic [CNT_W-1:0]                seen,
	output logic                            hit
);
	import mlpm_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);

	logic [MAX_PATTERN_LEN-1:0][7:0] pat_q;
	logic [LEN_W-1:0]                len_q;
	logic [LEN_W-1:0]                len_sat;
	logic [MAX_PATTERN_LEN-1:0][7:0] aligned;
	logic [MAX_PATTERN_LEN-1:0]      eq;

	// Pattern bytes carry no reset; the user, not the block, sees that an enabled length only covers written bytes.
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
			if (wr.byte_we && int'(wr.pos) == j) begin
				pat_q[j] <= wr.data;
			end
		end
	end

	always_comb begin
		if (int'(wr.len) > MAX_PATTERN_LEN) begin
			len_sat = LEN_W'(MAX_PATTERN_LEN);
		end else begin
			len_sat = LEN_W'(wr.len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (wr.len_we) begin
			len_q <= len_sat;
		end
	end

	// The last pattern byte lines up with the newest window byte.
	always_comb begin
		for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
			aligned[k] = '0;
			for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
				if (j + k + 1 == int'(len_q)) begin
					aligned[k] = pat_q[j];
				end
			end
			eq[k] = (k >= int'(len_q)) || (aligned[k] == window[k]);
		end
	end

	assign hit = enable && (len_q != '0) && (int'(len_q) <= int'(seen)) && (&eq);

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-literal payload matcher, with its scoreboard class.
module testbench;
	import mlpm_pkg::*;

	localparam int LANES      = 8;
	localparam int PAT_BYTES  = 32;
	localparam int SCAN_BYTES = 256;

	// The package names the three modes the block acts on; the fourth is only noise here.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Length of the random part, counted in requests the block acts on.
	localparam int RANDOM_ITEMS = 1650;
	localparam int PHASE_ITEMS  = 150;

	// The scoreboard keeps its own copy of the pattern table, the byte window and the
	// per-packet state. Every accepted request is replayed on that copy, and each request
	// that ends a packet leaves one expected verdict in a queue, oldest first.
	class match_scoreboard;
		logic [7:0] pattern_bytes [LANES][PAT_BYTES];
		logic [5:0] pattern_length [LANES];
		logic [7:0] window [PAT_BYTES];
		int unsigned scanned;
		logic [MASK_W-1:0] found;
		logic [ACTIVE_W-1:0] active;
		res_t expected_verdicts [$];
		int unsigned mismatch_count;

		function new();
			foreach (pattern_bytes[p, k]) pattern_bytes[p][k] = 8'h00;
			foreach (pattern_length[p]) pattern_length[p] = '0;
			active = '0;
			mismatch_count = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			foreach (window[k]) window[k] = 8'h00;
			scanned = 0;
			found = '0;
		endfunction

		// Shifts one payload byte into the window and compares every enabled lane. The
		// newest byte sits at index 0, so it lines up with the last byte of a pattern.
		function void scan_payload_byte(input logic [7:0] value);
			int unsigned lanes;
			int unsigned len;
			bit hit;
			if (scanned >= SCAN_BYTES)
				return;
			for (int k = PAT_BYTES - 1; k > 0; k--)
				window[k] = window[k - 1];
			window[0] = value;
			scanned++;
			lanes = (active > LANES) ? LANES : active;
			for (int p = 0; p < lanes; p++) begin
				len = pattern_length[p];
				if (len == 0 || len > scanned)
					continue;
				hit = 1'b1;
				for (int k = 0; k < len; k++)
					if (pattern_bytes[p][len - 1 - k] != window[k])
						hit = 1'b0;
				if (hit)
					found[p] = 1'b1;
			end
		endfunction

		function void accept_request(input req_t r);
			res_t verdict;
			case (r.mode)
				MODE_PAT_BYTE: begin
					pattern_bytes[r.pattern_index][r.pattern_pos] = r.data_byte;
				end
				MODE_PAT_LEN: begin
					pattern_length[r.pattern_index] =
						(r.pattern_len > PAT_BYTES) ? 6'(PAT_BYTES) : r.pattern_len;
				end
				MODE_PAYLOAD: begin
					// An empty packet marker scans nothing, but only when it ends the packet.
					if (!(r.last && r.empty_packet))
						scan_payload_byte(r.data_byte);
					if (r.last) begin
						verdict.match_mask = found;
						verdict.no_match = (found == '0);
						expected_verdicts.push_back(verdict);
						clear_packet();
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(input res_t got);
			res_t want;
			if (expected_verdicts.size() == 0) begin
				$error("result with no packet end waiting: match_mask %02h", got.match_mask);
				mismatch_count++;
				return;
			end
			want = expected_verdicts.pop_front();
			if (got.match_mask !== want.match_mask) begin
				$error("match_mask: expected %02h, actual %02h", want.match_mask, got.match_mask);
				mismatch_count++;
			end
			if (got.no_match !== want.no_match) begin
				$error("no_match: expected %b, actual %b", want.no_match, got.no_match);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ACTIVE_W-1:0] cfg_wdata;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;

	match_scoreboard board;

	// While calm is set neither side idles, so the block runs at full rate.
	bit calm;
	int unsigned items_sent;

	// What the stimulus knows of the pattern table, so that it can plant patterns in
	// payloads. A length is only ever set after all bytes under it have been written.
	logic [7:0] shadow_bytes [LANES][PAT_BYTES];
	logic [5:0] shadow_len [LANES];

	multi_literal_payload_matcher #(
		.NUM_PATTERNS(LANES),
		.MAX_PATTERN_LEN(PAT_BYTES),
		.SCAN_LIMIT(SCAN_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result side stalls at random with a chance of six in a hundred, except in calm phases.
	always @(posedge clk) begin
		res_stall <= !calm && ($urandom_range(0, 99) < 6);
	end

	// Results are taken at the edge where valid is high and our stall is low. Both are
	// read right after the edge, so they still hold the values from before it.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(res);
	end

	// Fields that the chosen mode ignores are left random, so all their bits toggle.
	function automatic req_t noisy_request(input logic [1:0] mode);
		logic [31:0] noise;
		req_t r;
		noise = $urandom;
		r = noise[$bits(req_t)-1:0];
		r.mode = mode;
		return r;
	endfunction

	// Mostly a three-letter alphabet so that short patterns turn up by chance as well.
	function automatic logic [7:0] payload_value();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		return 8'($urandom_range(8'h41, 8'h43));
	endfunction

	// Presents one request and holds it until the block takes it. The valid is only
	// lowered for a random gap, never between two back-to-back requests.
	task automatic send_request(input req_t r);
		while (!calm && $urandom_range(0, 99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		board.accept_request(r);
		if (r.mode != MODE_UNUSED)
			items_sent++;
	endtask

	task automatic put_pattern_byte(input int lane, input int pos, input logic [7:0] value);
		req_t r;
		r = noisy_request(MODE_PAT_BYTE);
		r.pattern_index = 3'(lane);
		r.pattern_pos = 5'(pos);
		r.data_byte = value;
		shadow_bytes[lane][pos] = value;
		send_request(r);
	endtask

	task automatic put_pattern_len(input int lane, input logic [5:0] len);
		req_t r;
		r = noisy_request(MODE_PAT_LEN);
		r.pattern_index = 3'(lane);
		r.pattern_len = len;
		shadow_len[lane] = (len > PAT_BYTES) ? 6'(PAT_BYTES) : len;
		send_request(r);
	endtask

	task automatic put_payload(input logic [7:0] value, input bit last, input bit empty);
		req_t r;
		r = noisy_request(MODE_PAYLOAD);
		r.data_byte = value;
		r.last = last;
		r.empty_packet = empty;
		send_request(r);
	endtask

	// Loads one lane: its bytes first, then its length. Lengths above the lane size
	// saturate in the block, so all of the lane's bytes are written for them.
	task automatic program_pattern(input int lane);
		int unsigned roll;
		int unsigned len;
		int unsigned span;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			len = $urandom_range(1, 4);
		else if (roll < 85)
			len = $urandom_range(5, PAT_BYTES);
		else if (roll < 90)
			len = 0;
		else
			len = $urandom_range(PAT_BYTES + 1, 63);
		span = (len > PAT_BYTES) ? PAT_BYTES : len;
		for (int k = 0; k < span; k++)
			put_pattern_byte(lane, k, payload_value());
		put_pattern_len(lane, 6'(len));
	endtask

	// One packet: usually short, now and then empty or near or past the scan limit in length. A known
	// pattern is often planted in it, in long packets often across the scan limit.
	task automatic send_packet();
		logic [7:0] body [];
		int unsigned roll;
		int unsigned count;
		int unsigned lane;
		int unsigned span;
		int unsigned start;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			count = 0;
		else if (roll < 9)
			count = $urandom_range(SCAN_BYTES - 16, SCAN_BYTES + 44);
		else
			count = $urandom_range(1, 40);
		if (count == 0) begin
			put_payload(payload_value(), 1'b1, 1'b1);
			return;
		end
		body = new[count];
		foreach (body[k]) body[k] = payload_value();
		lane = $urandom_range(0, LANES - 1);
		span = shadow_len[lane];
		if (span != 0 && span <= count && $urandom_range(0, 99) < 65) begin
			if (count > SCAN_BYTES && $urandom_range(0, 1) == 1)
				start = SCAN_BYTES - span + $urandom_range(0, 2);
			else
				start = $urandom_range(0, count - span);
			if (start + span > count)
				start = count - span;
			for (int k = 0; k < span; k++)
				body[start + k] = shadow_bytes[lane][k];
		end
		for (int k = 0; k < count; k++) begin
			// A pattern write in the middle of a packet acts from the next scanned byte.
			if ($urandom_range(0, 99) < 2)
				put_pattern_byte($urandom_range(0, LANES - 1), $urandom_range(0, PAT_BYTES - 1),
					payload_value());
			if (k == count - 1)
				put_payload(body[k], 1'b1, $urandom_range(0, 99) < 6);
			else
				put_payload(body[k], 1'b0, $urandom_range(0, 99) < 10);
		end
	endtask

	// Drains the block: every verdict in, then a wait for requests that give none and
	// may still sit in the input register.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (board.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_active(input logic [ACTIVE_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		board.active = value;
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		int unsigned phase_end;
		int unsigned roll;
		logic [ACTIVE_W-1:0] setting;
		board = new();
		calm = 1'b0;
		items_sent = 0;
		foreach (shadow_len[p]) shadow_len[p] = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Lane 0 holds the two extreme byte values, lane 7 a single byte.
		write_active(4'd8);
		put_pattern_byte(0, 0, 8'h00);
		put_pattern_byte(0, 1, 8'hFF);
		put_pattern_len(0, 6'd2);
		put_pattern_byte(7, 0, 8'h80);
		put_pattern_len(7, 6'd1);
		// A plain hit on lane 0.
		put_payload(8'h00, 1'b0, 1'b0);
		put_payload(8'hFF, 1'b1, 1'b0);
		// An empty packet on its own reports no match.
		put_payload(8'h5A, 1'b1, 1'b1);
		// The empty flag without last is ignored, so the byte still hits lane 7.
		put_payload(8'h80, 1'b0, 1'b1);
		put_payload(8'h11, 1'b1, 1'b0);
		// An empty end after real bytes reports what was found; its own byte is not scanned.
		put_payload(8'h00, 1'b0, 1'b0);
		put_payload(8'hFF, 1'b0, 1'b0);
		put_payload(8'h80, 1'b1, 1'b1);
		// The unused mode does nothing.
		send_request(noisy_request(MODE_UNUSED));
		// A length of zero disables lane 0.
		put_pattern_len(0, 6'd0);
		put_payload(8'h00, 1'b0, 1'b0);
		put_payload(8'hFF, 1'b1, 1'b0);
		// Lane 0 comes back in the middle of a packet and hits on the next byte.
		put_payload(8'h00, 1'b0, 1'b0);
		put_pattern_len(0, 6'd2);
		put_payload(8'hFF, 1'b1, 1'b0);

		// Random part in phases, each with its own register setting. The first three
		// phases take the extremes, including a count above the number of lanes.
		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase)
				0: setting = 4'd8;
				1: setting = 4'd15;
				2: setting = 4'd0;
				default: begin
					if ($urandom_range(0, 3) == 0)
						setting = 4'($urandom_range(0, 15));
					else
						setting = 4'($urandom_range(5, 15));
				end
			endcase
			write_active(setting);
			calm = (phase == 4 || phase == 5);
			if (phase == 0)
				for (int p = 0; p < LANES; p++)
					program_pattern(p);
			phase_end = items_sent + PHASE_ITEMS;
			if (phase_end > RANDOM_ITEMS)
				phase_end = RANDOM_ITEMS;
			while (items_sent < phase_end) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					program_pattern($urandom_range(0, LANES - 1));
				else if (roll < 14)
					send_request(noisy_request(MODE_UNUSED));
				else if (roll < 17)
					put_pattern_byte($urandom_range(0, LANES - 1), $urandom_range(0, PAT_BYTES - 1),
						payload_value());
				else
					send_packet();
			end
			phase++;
		end

		calm = 1'b0;
		wait_idle();
		repeat (4) @(posedge clk);
		if (board.mismatch_count == 0 && board.expected_verdicts.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// A timeout far beyond what a correct run needs.
	initial begin
		#5ms;
		$display("testbench failed");
		$finish;
	end

endmodule
